[sv/rvm_pkg.sv]
package rvm_pkg;

    localparam int ADC_BITS   = 12;
    localparam int PEAK_W     = 10;
    localparam int RISE_W     = PEAK_W + 1;
    localparam int PROD_W     = ADC_BITS + RISE_W;
    localparam int VMAG_W     = PROD_W;
    localparam int SQ_W       = 2 * VMAG_W;
    localparam int FRAC_SHIFT = 8;
    localparam int ROOT_W     = 27;
    localparam int SCL_W      = 2 * ROOT_W;
    localparam int RMS_W      = 28;
    localparam int SAMP_W     = 11;

    localparam int MAX_SAMPLES_DEF = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ADC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_ADC_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_VOLTS = 2'd2;

    localparam logic [ADC_BITS-1:0] ADC_LOW_RST    = 12'd2256;
    localparam logic [ADC_BITS-1:0] ADC_HIGH_RST   = 12'd3024;
    localparam logic [PEAK_W-1:0]   PEAK_VOLTS_RST = 10'd311;

endpackage

[sv/rvm_serial_div.sv]
module rvm_serial_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= num;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[sv/rvm_mapper.sv]
module rvm_mapper (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rvm_pkg::ADC_BITS-1:0]  sample,
    input  logic [rvm_pkg::ADC_BITS-1:0]  adc_low,
    input  logic [rvm_pkg::ADC_BITS-1:0]  adc_high,
    input  logic [rvm_pkg::PEAK_W-1:0]    peak_volts,
    output logic                          done,
    output logic [rvm_pkg::VMAG_W-1:0]    mag
);

    import rvm_pkg::*;

    localparam int CNT_W = $clog2(ADC_BITS + 1);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV
    } map_state_t;

    map_state_t           state_reg;
    logic [ADC_BITS-1:0]  mplier_reg;
    logic [PROD_W-1:0]    mcand_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ADC_BITS-1:0]  den_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 div_start_reg;
    logic                 done_reg;
    logic [VMAG_W-1:0]    mag_reg;

    logic [ADC_BITS:0]    delta;
    logic [ADC_BITS:0]    run;
    logic [ADC_BITS:0]    delta_abs;
    logic [ADC_BITS:0]    run_abs;
    logic [RISE_W-1:0]    rise;
    logic                 div_done;
    logic [PROD_W-1:0]    div_quo;
    logic [PROD_W+1:0]    q_signed;
    logic [PROD_W+1:0]    v_signed;
    logic [PROD_W+1:0]    v_abs;

    assign delta     = {1'b0, sample} - {1'b0, adc_low};
    assign run       = {1'b0, adc_high} - {1'b0, adc_low};
    assign delta_abs = delta[ADC_BITS] ? ('0 - delta) : delta;
    assign run_abs   = run[ADC_BITS] ? ('0 - run) : run;
    assign rise      = {peak_volts, 1'b0};

    assign q_signed = neg_reg ? ('0 - {2'b00, div_quo}) : {2'b00, div_quo};
    assign v_signed = q_signed - (PROD_W + 2)'(peak_volts);
    assign v_abs    = v_signed[PROD_W+1] ? ('0 - v_signed) : v_signed;

    rvm_serial_div #(
        .NUM_W(PROD_W),
        .DEN_W(ADC_BITS)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start_reg),
        .num    (prod_reg),
        .den    (den_reg),
        .done   (div_done),
        .quo    (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= M_IDLE;
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        if (run == '0) begin
                            mag_reg  <= VMAG_W'(1);
                            done_reg <= 1'b1;
                        end else begin
                            mplier_reg <= delta_abs[ADC_BITS-1:0];
                            mcand_reg  <= PROD_W'(rise);
                            prod_reg   <= '0;
                            den_reg    <= run_abs[ADC_BITS-1:0];
                            neg_reg    <= delta[ADC_BITS] ^ run[ADC_BITS];
                            cnt_reg    <= CNT_W'(ADC_BITS);
                            state_reg  <= M_MUL;
                        end
                    end
                end
                M_MUL: begin
                    if (mplier_reg[0]) begin
                        prod_reg <= prod_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        div_start_reg <= 1'b1;
                        state_reg     <= M_DIV;
                    end
                end
                M_DIV: begin
                    if (div_done) begin
                        mag_reg   <= v_abs[VMAG_W-1:0];
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign mag  = mag_reg;

endmodule

[sv/rvm_isqrt.sv]
module rvm_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rvm_pkg::SCL_W-1:0]   x,
    output logic                        done,
    output logic [rvm_pkg::ROOT_W-1:0]  root
);

    import rvm_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SCL_W-1:0]  x_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] test;
    logic [ROOT_W+2:0] diff;
    logic              fits;

    assign trial = {rem_reg, x_reg[SCL_W-1 -: 2]};
    assign test  = {1'b0, root_reg, 2'b01};
    assign fits  = trial >= test;
    assign diff  = trial - test;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= x;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                x_reg    <= x_reg << 2;
                rem_reg  <= fits ? diff[ROOT_W:0] : trial[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[sv/rms_voltage_meter_unit.sv]
// True RMS voltage meter. ADC words arrive on the s_ channel (s_sample, s_last) with a
// valid/ready handshake; s_last marks the final word of a measurement window. Each word is
// mapped to volts, squared and summed. The word with s_last set produces one result word on
// the m_ channel: the RMS voltage with four fractional bits, the number of samples used, an
// overflow flag for dropped samples and a flag for equal range ends.
// The block works on one word at a time. A word that is not last goes through a bit-serial
// multiply and a restoring divide, which map it to volts, and then a bit-serial square. The
// last word adds a serial division of the scaled sum by the count (one cycle per bit) and a
// square root. A word that arrives on a full window is dropped at once.
// The result sits in an output register, so a new window can start while the receiver
// stalls; the block waits only when a second result is ready and the first has not been
// taken. Reset clears the sums, the count and the overflow flag, empties the output register
// and loads the default range registers. Range registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce this.
module rms_voltage_meter_unit #(
    parameter int MAX_SAMPLES = rvm_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rvm_pkg::ADC_BITS-1:0]    s_sample,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rvm_pkg::RMS_W-1:0]       m_rms_q4,
    output logic [rvm_pkg::SAMP_W-1:0]      m_samples_used,
    output logic                            m_window_overflow,
    output logic                            m_range_error,
    input  logic                            cfg_we,
    input  logic [rvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import rvm_pkg::*;

    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = SQ_W + $clog2(MAX_SAMPLES);
    localparam int DNUM_W   = SUM_W + FRAC_SHIFT;
    localparam int SQ_CNT_W = $clog2(VMAG_W + 1);

    typedef enum logic [2:0] {
        T_IDLE,
        T_MAP,
        T_SQR,
        T_MEAN,
        T_ROOT,
        T_EMIT
    } top_state_t;

    top_state_t            state_reg;
    logic [ADC_BITS-1:0]   adc_low_reg;
    logic [ADC_BITS-1:0]   adc_high_reg;
    logic [PEAK_W-1:0]     peak_volts_reg;
    logic [ADC_BITS-1:0]   sample_reg;
    logic                  last_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  ovf_reg;
    logic [VMAG_W-1:0]     sq_mplier_reg;
    logic [SQ_W-1:0]       sq_mcand_reg;
    logic [SQ_CNT_W-1:0]   sq_cnt_reg;
    logic                  map_start_reg;
    logic                  mean_start_reg;
    logic                  root_start_reg;
    logic                  m_valid_reg;
    logic [RMS_W-1:0]      rms_reg;
    logic [SAMP_W-1:0]     used_reg;
    logic                  wovf_reg;
    logic                  rerr_reg;

    logic                  map_done;
    logic [VMAG_W-1:0]     map_mag;
    logic                  mean_done;
    logic [DNUM_W-1:0]     mean_quo;
    logic                  root_done;
    logic [ROOT_W-1:0]     root_val;

    assign s_ready = (state_reg == T_IDLE);

    rvm_mapper u_mapper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (map_start_reg),
        .sample    (sample_reg),
        .adc_low   (adc_low_reg),
        .adc_high  (adc_high_reg),
        .peak_volts(peak_volts_reg),
        .done      (map_done),
        .mag       (map_mag)
    );

    rvm_serial_div #(
        .NUM_W(DNUM_W),
        .DEN_W(CNT_W)
    ) u_mean_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mean_start_reg),
        .num    ({sum_reg, {FRAC_SHIFT{1'b0}}}),
        .den    (count_reg),
        .done   (mean_done),
        .quo    (mean_quo)
    );

    rvm_isqrt u_isqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (root_start_reg),
        .x      (mean_quo[SCL_W-1:0]),
        .done   (root_done),
        .root   (root_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_low_reg    <= ADC_LOW_RST;
            adc_high_reg   <= ADC_HIGH_RST;
            peak_volts_reg <= PEAK_VOLTS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ADC_LOW:    adc_low_reg    <= cfg_data[ADC_BITS-1:0];
                CFG_ADC_HIGH:   adc_high_reg   <= cfg_data[ADC_BITS-1:0];
                CFG_PEAK_VOLTS: peak_volts_reg <= cfg_data[PEAK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            sum_reg        <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            map_start_reg  <= 1'b0;
            mean_start_reg <= 1'b0;
            root_start_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            map_start_reg  <= 1'b0;
            mean_start_reg <= 1'b0;
            root_start_reg <= 1'b0;
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (s_valid) begin
                        sample_reg <= s_sample;
                        last_reg   <= s_last;
                        if (count_reg < CNT_W'(MAX_SAMPLES)) begin
                            map_start_reg <= 1'b1;
                            state_reg     <= T_MAP;
                        end else begin
                            ovf_reg <= 1'b1;
                            if (s_last) begin
                                mean_start_reg <= 1'b1;
                                state_reg      <= T_MEAN;
                            end
                        end
                    end
                end
                T_MAP: begin
                    if (map_done) begin
                        sq_mplier_reg <= map_mag;
                        sq_mcand_reg  <= SQ_W'(map_mag);
                        sq_cnt_reg    <= SQ_CNT_W'(VMAG_W);
                        state_reg     <= T_SQR;
                    end
                end
                T_SQR: begin
                    if (sq_mplier_reg[0]) begin
                        sum_reg <= sum_reg + SUM_W'(sq_mcand_reg);
                    end
                    sq_mcand_reg  <= sq_mcand_reg << 1;
                    sq_mplier_reg <= sq_mplier_reg >> 1;
                    sq_cnt_reg    <= sq_cnt_reg - 1'b1;
                    if (sq_cnt_reg == SQ_CNT_W'(1)) begin
                        count_reg <= count_reg + 1'b1;
                        if (last_reg) begin
                            mean_start_reg <= 1'b1;
                            state_reg      <= T_MEAN;
                        end else begin
                            state_reg <= T_IDLE;
                        end
                    end
                end
                T_MEAN: begin
                    if (mean_done) begin
                        root_start_reg <= 1'b1;
                        state_reg      <= T_ROOT;
                    end
                end
                T_ROOT: begin
                    if (root_done) begin
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        rms_reg     <= (count_reg == '0) ? '0 : RMS_W'(root_val);
                        used_reg    <= SAMP_W'(count_reg);
                        wovf_reg    <= ovf_reg;
                        rerr_reg    <= (adc_low_reg == adc_high_reg);
                        m_valid_reg <= 1'b1;
                        sum_reg     <= '0;
                        count_reg   <= '0;
                        ovf_reg     <= 1'b0;
                        state_reg   <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_rms_q4          = rms_reg;
    assign m_samples_used    = used_reg;
    assign m_window_overflow = wovf_reg;
    assign m_range_error     = rerr_reg;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

typedef struct packed {
    logic [rvm_pkg::RMS_W-1:0]  rms_q4;
    logic [rvm_pkg::SAMP_W-1:0] samples_used;
    logic                       window_overflow;
    logic                       range_error;
} rms_word_t;

class rms_scoreboard;
    logic [rvm_pkg::ADC_BITS-1:0] adc_low;
    logic [rvm_pkg::ADC_BITS-1:0] adc_high;
    logic [rvm_pkg::PEAK_W-1:0]   peak_volts;
    logic [63:0]                  sum_squares;
    logic [31:0]                  sample_total;
    bit                           overflow_seen;
    rms_word_t                    pending[$];
    int                           errors;

    function new();
        adc_low       = rvm_pkg::ADC_LOW_RST;
        adc_high      = rvm_pkg::ADC_HIGH_RST;
        peak_volts    = rvm_pkg::PEAK_VOLTS_RST;
        sum_squares   = '0;
        sample_total  = '0;
        overflow_seen = 1'b0;
        errors        = 0;
    endfunction

    function void report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endfunction

    function void write_reg(logic [rvm_pkg::CFG_IDX_W-1:0] idx,
                            logic [rvm_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rvm_pkg::CFG_ADC_LOW:    adc_low = data;
            rvm_pkg::CFG_ADC_HIGH:   adc_high = data;
            rvm_pkg::CFG_PEAK_VOLTS: peak_volts = data[rvm_pkg::PEAK_W-1:0];
            default: ;
        endcase
    endfunction

    function longint volts_of(logic [rvm_pkg::ADC_BITS-1:0] code);
        longint span;
        longint rise;
        longint delta;
        span  = longint'(adc_high) - longint'(adc_low);
        rise  = 2 * longint'(peak_volts);
        delta = longint'(code) - longint'(adc_low);
        if (span == 0) return -1;
        return (delta * rise) / span - longint'(peak_volts);
    endfunction

    function logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
        end
        return root;
    endfunction

    function logic [63:0] window_rms();
        logic [63:0] n;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] scaled;
        if (sample_total == 0) return '0;
        n      = {32'd0, sample_total};
        q      = sum_squares / n;
        r      = sum_squares % n;
        scaled = (q << rvm_pkg::FRAC_SHIFT) + ((r << rvm_pkg::FRAC_SHIFT) / n);
        return root_floor(scaled);
    endfunction

    function void note_word(logic [rvm_pkg::ADC_BITS-1:0] code, logic last);
        longint      v;
        logic [63:0] mag;
        logic [63:0] rms;
        rms_word_t   w;
        if (sample_total < rvm_pkg::MAX_SAMPLES_DEF) begin
            v   = volts_of(code);
            mag = (v < 0) ? -v : v;
            sum_squares  += mag * mag;
            sample_total += 1;
        end else begin
            overflow_seen = 1'b1;
        end
        if (last) begin
            rms               = window_rms();
            w.rms_q4          = rms[rvm_pkg::RMS_W-1:0];
            w.samples_used    = sample_total[rvm_pkg::SAMP_W-1:0];
            w.window_overflow = overflow_seen;
            w.range_error     = (adc_low == adc_high);
            pending.push_back(w);
            sum_squares   = '0;
            sample_total  = '0;
            overflow_seen = 1'b0;
        end
    endfunction

    function void check_result(rms_word_t got);
        rms_word_t want;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("result word with none expected, rms_q4=%0d",
                                      got.rms_q4));
            return;
        end
        want = pending.pop_front();
        if (got.rms_q4 !== want.rms_q4)
            report_mismatch($sformatf("rms_q4 got %0d want %0d", got.rms_q4, want.rms_q4));
        if (got.samples_used !== want.samples_used)
            report_mismatch($sformatf("samples_used got %0d want %0d",
                                      got.samples_used, want.samples_used));
        if (got.window_overflow !== want.window_overflow)
            report_mismatch($sformatf("window_overflow got %0b want %0b",
                                      got.window_overflow, want.window_overflow));
        if (got.range_error !== want.range_error)
            report_mismatch($sformatf("range_error got %0b want %0b",
                                      got.range_error, want.range_error));
    endfunction
endclass

module tb;
    localparam int LIMIT_CYCLES  = 1500000;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 4000;
    localparam int GAP_MAX       = 12;
    localparam int MAX_SAMPLES   = rvm_pkg::MAX_SAMPLES_DEF;
    localparam logic [rvm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [rvm_pkg::ADC_BITS-1:0]    s_sample;
    logic                            s_last;
    logic                            m_valid;
    logic                            m_ready;
    logic [rvm_pkg::RMS_W-1:0]       m_rms_q4;
    logic [rvm_pkg::SAMP_W-1:0]      m_samples_used;
    logic                            m_window_overflow;
    logic                            m_range_error;
    logic                            cfg_we;
    logic [rvm_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [rvm_pkg::CFG_DATA_W-1:0]  cfg_data;

    rms_scoreboard sb;
    bit            s_steady;
    bit            m_steady;
    bit            hold_req;
    int unsigned   cycle_count = 0;

    rms_voltage_meter_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rms_q4          (m_rms_q4),
        .m_samples_used    (m_samples_used),
        .m_window_overflow (m_window_overflow),
        .m_range_error     (m_range_error),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_word(input logic [rvm_pkg::ADC_BITS-1:0] code, input logic last);
        int gap;
        gap = s_steady ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= code;
        s_last   <= last;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.note_word(code, last);
    endtask

    task automatic write_cfg(input logic [rvm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rvm_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_range(input logic [11:0] lo, input logic [11:0] hi,
                             input logic [11:0] pk);
        write_cfg(rvm_pkg::CFG_ADC_LOW, lo);
        write_cfg(rvm_pkg::CFG_ADC_HIGH, hi);
        write_cfg(rvm_pkg::CFG_PEAK_VOLTS, pk);
    endtask

    task automatic drain_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [rvm_pkg::ADC_BITS-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return 12'($urandom_range(sb.adc_low, sb.adc_high));
            default:    return 12'($urandom);
        endcase
    endfunction

    function automatic int window_len();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $urandom_range(1, 4);
        if (sel < 9) return $urandom_range(5, 12);
        return $urandom_range(13, 40);
    endfunction

    initial begin : result_sink
        int        gap;
        rms_word_t got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            gap = m_steady ? 0 : $urandom_range(0, GAP_MAX);
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            got.rms_q4          = m_rms_q4;
            got.samples_used    = m_samples_used;
            got.window_overflow = m_window_overflow;
            got.range_error     = m_range_error;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        int          target;
        int          left;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [11:0] pk;
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_sample  = '0;
        s_last    = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_steady  = 1'b0;
        m_steady  = 1'b0;
        hold_req  = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset range, one-word windows at code extremes, then in/out-of-range codes.
        send_word(12'd0, 1'b1);
        send_word(12'd4095, 1'b1);
        send_word(12'd2256, 1'b0);
        send_word(12'd3024, 1'b0);
        send_word(12'd2640, 1'b1);
        send_word(12'd100, 1'b0);
        send_word(12'd4000, 1'b1);
        drain_block();

        set_range(12'd0, 12'd4095, 12'd1023);
        send_word(12'd0, 1'b0);
        send_word(12'd4095, 1'b1);
        drain_block();

        set_range(12'd4095, 12'd0, 12'hFFF);
        send_word(12'd0, 1'b0);
        send_word(12'd2048, 1'b0);
        send_word(12'd4095, 1'b1);
        drain_block();

        // Equal range ends, and windows that change the range before their last word.
        set_range(12'd1000, 12'd1000, 12'd311);
        send_word(12'd1000, 1'b0);
        send_word(12'd5, 1'b1);
        send_word(12'd77, 1'b0);
        drain_block();
        write_cfg(rvm_pkg::CFG_ADC_HIGH, 12'd1500);
        send_word(12'd1200, 1'b1);
        send_word(12'd1100, 1'b0);
        drain_block();
        write_cfg(rvm_pkg::CFG_ADC_HIGH, 12'd1000);
        send_word(12'd4095, 1'b1);
        drain_block();

        set_range(12'd1000, 12'd1001, 12'd1023);
        send_word(12'd4095, 1'b1);
        drain_block();

        write_cfg(rvm_pkg::CFG_PEAK_VOLTS, 12'd0);
        send_word(12'd1234, 1'b1);
        send_word(12'd4095, 1'b0);
        send_word(12'd0, 1'b1);
        drain_block();

        left = 0;
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: set_range(rvm_pkg::ADC_LOW_RST, rvm_pkg::ADC_HIGH_RST,
                             rvm_pkg::PEAK_VOLTS_RST);
                1: set_range(12'd0, 12'd4095, 12'd1023);
                2: set_range(12'd4095, 12'd0, 12'd1023);
                3: begin
                    lo = 12'($urandom);
                    set_range(lo, lo, 12'($urandom));
                end
                4: set_range(12'd2047, 12'd2048, 12'd1023);
                5: set_range(12'($urandom), 12'($urandom), 12'd0);
                default: begin
                    lo = 12'($urandom);
                    hi = ($urandom_range(0, 5) == 0) ? lo : 12'($urandom);
                    pk = 12'($urandom);
                    set_range(lo, hi, pk);
                end
            endcase
            if (ph == 8) write_cfg(CFG_SPARE, 12'($urandom));
            s_steady = ($urandom_range(0, 3) == 0);
            m_steady = ($urandom_range(0, 3) == 0);
            if (ph == 6) begin
                s_steady = 1'b1;
                hold_req = 1'b1;
            end
            target = $urandom_range(40, 60);
            for (int k = 0; k < target; k++) begin
                if (left == 0) left = window_len();
                left--;
                send_word(pick_sample(), left == 0);
            end
            if (ph == 9) begin
                while (sb.sample_total < MAX_SAMPLES) send_word(pick_sample(), 1'b0);
                repeat (3) send_word(pick_sample(), 1'b0);
                send_word(pick_sample(), 1'b1);
                left = 0;
            end
            drain_block();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
